// ===== design/jdps_pkg.sv =====
// Package for the jump-diffusion price step: payload structs, register
// indexes, fixed-point constants. No dependencies.
`default_nettype none
package jdps_pkg;
  localparam int SampleWidth = 16;
  localparam int PriceFracBits = 16;
  localparam int HornerTerms = 12;

  localparam logic [31:0] Log2eQ30 = 32'd1549082005;
  localparam logic [31:0] Ln2Q30 = 32'd744261118;
  localparam logic [36:0] LrLimit = 37'd40 << 28;

  localparam logic [2:0] RegLogDrift = 3'd0;
  localparam logic [2:0] RegDiffScale = 3'd1;
  localparam logic [2:0] RegJumpProb = 3'd2;
  localparam logic [2:0] RegJumpMean = 3'd3;
  localparam logic [2:0] RegJumpStd = 3'd4;
  localparam logic [2:0] RegInitPrice = 3'd5;

  typedef struct packed {
    logic                          start_path;
    logic signed [SampleWidth-1:0] normal_sample;
    logic [15:0]                   uniform_sample;
    logic signed [SampleWidth-1:0] jump_normal_sample;
  } in_item_t;

  typedef struct packed {
    logic [31:0] price;
    logic        jumped;
    logic        saturated;
  } out_item_t;

  // Classified step passed from front to back.
  typedef struct packed {
    logic        start_path;
    logic        jumped;
    logic signed [7:0] n;
    logic [27:0] f;
  } step_t;

  typedef struct packed {
    logic signed [31:0] log_drift;
    logic [31:0]        diffusion_scale;
    logic [16:0]        jump_probability;
    logic signed [31:0] jump_mu;
    logic [31:0]        jump_sigma;
    logic [31:0]        init_price;
  } cfg_t;
endpackage
`default_nettype wire

// ===== design/jdps_front.sv =====
// Front part: builds the log return, clamps it and splits y = lr*log2(e)
// into integer and fraction. Depends on jdps_pkg.
`default_nettype none
module jdps_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire jdps_pkg::cfg_t     cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire jdps_pkg::in_item_t in_data_i,
  output logic                    step_valid_o,
  input  wire logic               step_ready_i,
  output jdps_pkg::step_t         step_o
);
  localparam int SW = jdps_pkg::SampleWidth;

  // stage 1: scaled samples
  logic s1_valid_q, s1_start_q, s1_jump_q, s1_nneg_q, s1_jneg_q;
  logic [SW+31:0] s1_np_q, s1_jp_q;
  // stage 2: clamped log-return magnitude
  logic s2_valid_q, s2_start_q, s2_jump_q, s2_neg_q;
  logic [36:0] s2_mag_q;
  // stage 3: output
  logic s3_valid_q;
  jdps_pkg::step_t s3_q;

  logic adv3, adv2, adv1;
  assign adv3 = !s3_valid_q || step_ready_i;
  assign adv2 = !s2_valid_q || adv3;
  assign adv1 = !s1_valid_q || adv2;
  assign in_ready_o = adv1;

  logic [SW-1:0] nmag, jmag;
  assign nmag = in_data_i.normal_sample[SW-1] ? SW'(-in_data_i.normal_sample)
                                              : in_data_i.normal_sample;
  assign jmag = in_data_i.jump_normal_sample[SW-1] ?
                SW'(-in_data_i.jump_normal_sample) : in_data_i.jump_normal_sample;

  // Signed sum of terms, 40 bits is ample.
  logic signed [39:0] nterm, jterm, lr;
  logic [39:0] lrmag;
  always_comb begin
    nterm = 40'(s1_np_q >> (SW-2));
    if (s1_nneg_q) nterm = -nterm;
    jterm = 40'(s1_jp_q >> (SW-2));
    if (s1_jneg_q) jterm = -jterm;
    lr = 40'(cfg_i.log_drift) + nterm;
    if (s1_jump_q) lr = lr + 40'(cfg_i.jump_mu) + jterm;
    lrmag = lr[39] ? 40'(-lr) : 40'(lr);
    if (lrmag > 40'(jdps_pkg::LrLimit)) lrmag = 40'(jdps_pkg::LrLimit);
  end

  logic [68:0] ymul;
  logic [38:0] ymag;
  logic [27:0] fr;
  logic signed [7:0] nn;
  always_comb begin
    ymul = 69'(s2_mag_q) * 69'(jdps_pkg::Log2eQ30);
    ymag = ymul[68:30];
    fr = ymag[27:0];
    nn = 8'(ymag[38:28]);
    if (s2_neg_q) begin
      nn = -nn;
      if (fr != '0) begin
        nn = nn - 8'sd1;
        fr = 28'(29'd1 << 28) - fr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= in_valid_i;
      if (adv2) s2_valid_q <= s1_valid_q;
      if (adv3) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_start_q <= in_data_i.start_path;
      s1_jump_q <= {1'b0, in_data_i.uniform_sample} < cfg_i.jump_probability;
      s1_nneg_q <= in_data_i.normal_sample[SW-1];
      s1_jneg_q <= in_data_i.jump_normal_sample[SW-1];
      s1_np_q <= (SW+32)'(cfg_i.diffusion_scale) * (SW+32)'(nmag);
      s1_jp_q <= (SW+32)'(cfg_i.jump_sigma) * (SW+32)'(jmag);
    end
    if (adv2) begin
      s2_start_q <= s1_start_q;
      s2_jump_q <= s1_jump_q;
      s2_neg_q <= lr[39];
      s2_mag_q <= 37'(lrmag);
    end
    if (adv3) begin
      s3_q.start_path <= s2_start_q;
      s3_q.jumped <= s2_jump_q;
      s3_q.n <= nn;
      s3_q.f <= fr;
    end
  end

  assign step_valid_o = s3_valid_q;
  assign step_o = s3_q;
endmodule
`default_nettype wire

// ===== design/jdps_queue.sv =====
// Two-entry queue between front and back. Depends on jdps_pkg.
`default_nettype none
module jdps_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_valid_i,
  output logic                 wr_ready_o,
  input  wire jdps_pkg::step_t wr_data_i,
  output logic                 rd_valid_o,
  input  wire logic            rd_ready_i,
  output jdps_pkg::step_t      rd_data_o
);
  jdps_pkg::step_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;
  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule
`default_nettype wire

// ===== design/jdps_back.sv =====
// Back part: Horner exp2 of the fraction, then the running-price multiply
// and shift with saturation. Depends on jdps_pkg.
`default_nettype none
module jdps_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [31:0]     init_price_i,
  input  wire logic            step_valid_i,
  output logic                 step_ready_o,
  input  wire jdps_pkg::step_t step_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output jdps_pkg::out_item_t  out_data_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StX    = 3'd1;
  localparam logic [2:0] StHorn = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StMul  = 3'd4;

  logic [2:0] st_q;
  logic [3:0] k_q;
  logic [30:0] x_q, acc_q;
  logic [31:0] aprod_q;
  jdps_pkg::step_t cur_q;
  logic [31:0] run_q;
  logic out_valid_q;
  jdps_pkg::out_item_t out_q;
  logic load;

  assign step_ready_o = st_q == StIdle;

  // Divide by k as a multiply by ceil(2^35/k); exact for products below 2^31.
  logic [58:0] xmul;
  logic [61:0] amul;
  logic [35:0] recip;
  logic [67:0] qmul;
  logic [30:0] aq;
  always_comb begin
    xmul = 59'(cur_q.f) * 59'(jdps_pkg::Ln2Q30);
    amul = 62'(acc_q) * 62'(x_q);
    unique case (k_q)
      4'd1:    recip = 36'd34359738368;
      4'd2:    recip = 36'd17179869184;
      4'd3:    recip = 36'd11453246123;
      4'd4:    recip = 36'd8589934592;
      4'd5:    recip = 36'd6871947674;
      4'd6:    recip = 36'd5726623062;
      4'd7:    recip = 36'd4908534053;
      4'd8:    recip = 36'd4294967296;
      4'd9:    recip = 36'd3817748708;
      4'd10:   recip = 36'd3435973837;
      4'd11:   recip = 36'd3123612579;
      4'd12:   recip = 36'd2863311531;
      default: recip = '0;
    endcase
    qmul = 68'(aprod_q) * 68'(recip);
    aq = 31'(qmul >> 35);
  end

  // Final scale: prod = base * 2^f (Q.30), shift by n-30.
  logic [31:0] base;
  logic [62:0] prod;
  logic [31:0] price;
  logic sat;
  logic signed [8:0] sh;
  logic [63:0] lim;
  always_comb begin
    base = cur_q.start_path ? init_price_i : run_q;
    prod = 63'(base) * 63'(acc_q);
    sh = 9'(cur_q.n) - 9'sd30;
    sat = 1'b0;
    price = '0;
    lim = '0;
    if (sh <= 0) begin
      if (-sh >= 63) price = '0;
      else if ((prod >> (-sh)) > 63'hFFFFFFFF) begin
        price = '1;
        sat = 1'b1;
      end else price = 32'(prod >> (-sh));
    end else begin
      lim = 64'hFFFFFFFF >> sh;
      if (64'(prod) > lim) begin
        price = '1;
        sat = 1'b1;
      end else price = 32'(prod << sh);
    end
  end

  assign load = (st_q == StMul) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      run_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= load || (out_valid_q && !out_ready_i);
      if (load) run_q <= price;
      unique case (st_q)
        StIdle: if (step_valid_i) st_q <= StX;
        StX: st_q <= StHorn;
        StHorn: st_q <= StDiv;
        StDiv: st_q <= (k_q == 4'd1) ? StMul : StHorn;
        StMul: if (load) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: if (step_valid_i) cur_q <= step_i;
      StX: begin
        x_q <= 31'(xmul >> 28);
        acc_q <= 31'(1) << 30;
        k_q <= 4'(jdps_pkg::HornerTerms);
      end
      StHorn: aprod_q <= 32'(amul >> 30);
      StDiv: begin
        acc_q <= (31'(1) << 30) + aq;
        k_q <= k_q - 4'd1;
      end
      StMul: if (load) begin
        out_q.price <= price;
        out_q.jumped <= cur_q.jumped;
        out_q.saturated <= sat;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
endmodule
`default_nettype wire

// ===== design/jump_diffusion_price_step.sv =====
// Top level of the jump-diffusion price step: APB registers, front, queue,
// back. Depends on jdps_pkg, jdps_front, jdps_queue, jdps_back.
//
// Usage: each input transaction (in_valid_i/in_ready_o, in_data_i) is one
// Euler step of a Monte Carlo path; each output transaction
// (out_valid_o/out_ready_i, out_data_o) returns the new price, the jump flag
// and the saturation flag, one result per input, in order.
// The front forms the log return (sample products, drift, jump term, clamp
// to +-40) and splits lr*log2(e) into n and f over three pipeline stages.
// A two-entry queue decouples it from the back, which evaluates 2^f with a
// 12-term Horner loop, each term a multiply, then a divide by k
// through a reciprocal multiply, and then scales the running price.
// The back holds one step at a time and takes no new step until its
// result is loaded into the output register.
// Reset clears the running price to 0 and loads register defaults
// (initial price 100.0). A stalled receiver holds the output register;
// the back waits, the queue and front fill and then drop in_ready_o.
// Registers are to be written through APB only while idle; the block does not enforce this.
`default_nettype none
module jump_diffusion_price_step (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire jdps_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output jdps_pkg::out_item_t      out_data_o
);
  jdps_pkg::cfg_t cfg_q;
  logic [2:0] ridx;
  assign ridx = paddr[4:2];
  assign pready = 1'b1;

  // Write on the access cycle; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.log_drift <= '0;
      cfg_q.diffusion_scale <= '0;
      cfg_q.jump_probability <= '0;
      cfg_q.jump_mu <= '0;
      cfg_q.jump_sigma <= '0;
      cfg_q.init_price <= 32'(100) << jdps_pkg::PriceFracBits;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        jdps_pkg::RegLogDrift:  cfg_q.log_drift <= pwdata;
        jdps_pkg::RegDiffScale: cfg_q.diffusion_scale <= pwdata;
        jdps_pkg::RegJumpProb:  cfg_q.jump_probability <= pwdata[16:0];
        jdps_pkg::RegJumpMean:  cfg_q.jump_mu <= pwdata;
        jdps_pkg::RegJumpStd:   cfg_q.jump_sigma <= pwdata;
        jdps_pkg::RegInitPrice: cfg_q.init_price <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      jdps_pkg::RegLogDrift:  prdata = cfg_q.log_drift;
      jdps_pkg::RegDiffScale: prdata = cfg_q.diffusion_scale;
      jdps_pkg::RegJumpProb:  prdata = 32'(cfg_q.jump_probability);
      jdps_pkg::RegJumpMean:  prdata = cfg_q.jump_mu;
      jdps_pkg::RegJumpStd:   prdata = cfg_q.jump_sigma;
      jdps_pkg::RegInitPrice: prdata = cfg_q.init_price;
      default:                prdata = '0;
    endcase
  end

  logic f_valid, f_ready, b_valid, b_ready;
  jdps_pkg::step_t f_step, b_step;

  jdps_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_valid_i, .in_ready_o, .in_data_i,
    .step_valid_o(f_valid), .step_ready_i(f_ready), .step_o(f_step)
  );

  jdps_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready),
    .wr_data_i(f_step), .rd_valid_o(b_valid), .rd_ready_i(b_ready),
    .rd_data_o(b_step)
  );

  jdps_back u_back (
    .clk_i, .rst_ni, .init_price_i(cfg_q.init_price),
    .step_valid_i(b_valid), .step_ready_o(b_ready), .step_i(b_step),
    .out_valid_o, .out_ready_i, .out_data_o
  );

  // A saturated result always carries the maximum price.
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |-> out_data_o.price == 32'hFFFFFFFF)
    else $error("saturated result without maximum price");
  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
endmodule
`default_nettype wire

// ===== test/jdps_checker.sv =====
// Checker for the jump-diffusion price step: watches the config port and both
// channels, predicts each price step and compares. Depends on jdps_pkg.
`timescale 1ns / 1ps
module jdps_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  input  wire logic                pready,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_o,
  input  wire jdps_pkg::in_item_t  in_data_i,
  input  wire logic                out_valid_o,
  input  wire logic                out_ready_i,
  input  wire jdps_pkg::out_item_t out_data_o,
  output int                       fail_count,
  output int                       pending_count
);
  jdps_pkg::cfg_t      cfg_q;
  logic [31:0]         path_price;
  jdps_pkg::out_item_t price_queue[$];

  function automatic logic signed [63:0] scale_sample(logic [31:0] scale,
                                                      logic [15:0] raw);
    logic [63:0] mag;
    logic [63:0] prod;
    mag = raw[15] ? (64'd65536 - {48'd0, raw}) : {48'd0, raw};
    prod = ({32'd0, scale} * mag) >> 14;
    return raw[15] ? -$signed(prod) : $signed(prod);
  endfunction

  function automatic logic [63:0] pow2_frac(logic [63:0] f);
    logic [63:0] x;
    logic [63:0] acc;
    x = (f * 64'd744261118) >> 28;
    acc = 64'd1 << 30;
    for (int k = 12; k >= 1; k--) acc = (64'd1 << 30) + ((acc * x) >> 30) / k;
    return acc;
  endfunction

  function automatic jdps_pkg::out_item_t predict_step(jdps_pkg::in_item_t it);
    jdps_pkg::out_item_t r;
    logic [63:0] base, mag, ymag, f, prod, lim;
    logic signed [63:0] lr, n, s;
    logic neg;
    base = it.start_path ? {32'd0, cfg_q.init_price} : {32'd0, path_price};
    r.jumped = {1'b0, it.uniform_sample} < cfg_q.jump_probability;
    r.saturated = 1'b0;
    lr = 64'(cfg_q.log_drift) + scale_sample(cfg_q.diffusion_scale, it.normal_sample);
    if (r.jumped)
      lr += 64'(cfg_q.jump_mu) + scale_sample(cfg_q.jump_sigma, it.jump_normal_sample);
    if (lr > (64'sd40 <<< 28)) lr = 64'sd40 <<< 28;
    if (lr < -(64'sd40 <<< 28)) lr = -(64'sd40 <<< 28);
    neg = lr < 0;
    mag = neg ? -lr : lr;
    ymag = (mag * 64'd1549082005) >> 30;
    f = ymag & ((64'd1 << 28) - 1);
    n = $signed(ymag >> 28);
    if (neg) begin
      n = -n;
      if (f != 0) begin
        n -= 1;
        f = (64'd1 << 28) - f;
      end
    end
    prod = base * pow2_frac(f);
    if (n <= 30) begin
      s = 30 - n;
      prod = (s >= 64) ? 64'd0 : prod >> s;
      if (prod > 64'hFFFF_FFFF) begin
        prod = 64'hFFFF_FFFF;
        r.saturated = 1'b1;
      end
    end else begin
      s = n - 30;
      lim = (s >= 64) ? 64'd0 : 64'hFFFF_FFFF >> s;
      if (prod > lim) begin
        prod = 64'hFFFF_FFFF;
        r.saturated = 1'b1;
      end else prod = prod << s;
    end
    r.price = prod[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch %s got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    jdps_pkg::out_item_t want;
    if (!rst_ni) begin
      cfg_q.log_drift <= '0;
      cfg_q.diffusion_scale <= '0;
      cfg_q.jump_probability <= '0;
      cfg_q.jump_mu <= '0;
      cfg_q.jump_sigma <= '0;
      cfg_q.init_price <= 32'd100 << 16;
      path_price <= '0;
      fail_count = 0;
      pending_count <= 0;
    end else begin
      // track register writes to mirror the configuration
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          jdps_pkg::RegLogDrift:  cfg_q.log_drift <= pwdata;
          jdps_pkg::RegDiffScale: cfg_q.diffusion_scale <= pwdata;
          jdps_pkg::RegJumpProb:  cfg_q.jump_probability <= pwdata[16:0];
          jdps_pkg::RegJumpMean:  cfg_q.jump_mu <= pwdata;
          jdps_pkg::RegJumpStd:   cfg_q.jump_sigma <= pwdata;
          jdps_pkg::RegInitPrice: cfg_q.init_price <= pwdata;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        want = predict_step(in_data_i);
        price_queue.push_back(want);
        path_price <= want.price;
      end
      if (out_valid_o && out_ready_i) begin
        if (price_queue.size() == 0) begin
          report_mismatch("unexpected transaction", out_data_o.price, 32'd0);
        end else begin
          want = price_queue.pop_front();
          if (out_data_o.price !== want.price)
            report_mismatch("price", out_data_o.price, want.price);
          if (out_data_o.jumped !== want.jumped)
            report_mismatch("jumped", 32'(out_data_o.jumped), 32'(want.jumped));
          if (out_data_o.saturated !== want.saturated)
            report_mismatch("saturated", 32'(out_data_o.saturated),
                            32'(want.saturated));
        end
      end
      pending_count <= price_queue.size();
    end
  end
endmodule

// ===== test/jump_diffusion_price_step_tb.sv =====
// Testbench top for the jump-diffusion price step: drives APB configuration
// and step transactions, gives the verdict. Depends on jdps_pkg, jdps_checker.
`timescale 1ns / 1ps
module jump_diffusion_price_step_tb;
  localparam int WatchdogLimit = 20000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [4:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  jdps_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  jdps_pkg::out_item_t out_data_o;
  int                  fail_count;
  int                  pending_count;
  int                  idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  jump_diffusion_price_step dut (.*);
  jdps_checker checker_i (.*);

  // Short gaps mostly, now and then a long one; some stretches run back to back.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Hold valid and payload until the handshake completes; valid stays high
  // into the next transaction when there is no gap.
  task automatic send_step(logic sp, logic [15:0] ns, logic [15:0] us, logic [15:0] js);
    jdps_pkg::in_item_t it;
    int gap;
    it.start_path = sp;
    it.normal_sample = ns;
    it.uniform_sample = us;
    it.jump_normal_sample = js;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and drain before any register write.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_all(logic [31:0] ld, logic [31:0] ds, logic [31:0] jp,
                           logic [31:0] jm, logic [31:0] js, logic [31:0] ip);
    write_reg(jdps_pkg::RegLogDrift, ld);
    write_reg(jdps_pkg::RegDiffScale, ds);
    write_reg(jdps_pkg::RegJumpProb, jp);
    write_reg(jdps_pkg::RegJumpMean, jm);
    write_reg(jdps_pkg::RegJumpStd, js);
    write_reg(jdps_pkg::RegInitPrice, ip);
  endtask

  task automatic random_phase(int count);
    logic sp;
    for (int i = 0; i < count; i++) begin
      sp = ($urandom_range(0, 15) == 0);
      send_step(sp, 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  // Random receiver stalls.
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 99) < 8) ? 1'b0 :
                        ($urandom_range(0, 99) < 70);
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("** jump_diffusion_price_step: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: no start after reset keeps price at zero.
    send_step(1'b0, 16'h1000, 16'hFFFF, 16'h0000);
    send_step(1'b0, 16'h7FFF, 16'h0000, 16'h8000);
    // Defaults: start from 100.0, zero log return.
    send_step(1'b1, 16'h0000, 16'h0000, 16'h0000);
    wait_idle();
    write_all(32'h0010_0000, 32'h1000_0000, 32'h0000_8000, 32'hF800_0000,
              32'h0800_0000, 32'd100 << 16);
    send_step(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_step(1'b0, 16'h8000, 16'h8000, 16'h8000);
    send_step(1'b0, 16'hFFFF, 16'h0000, 16'h0001);
    send_step(1'b0, 16'h0001, 16'hFFFF, 16'hFFFF);
    wait_idle();
    // Always jump, huge positive return: saturate and hold the clip; then a negative return drops the price to zero.
    write_all(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_step(1'b1, 16'h7FFF, 16'hFFFF, 16'h7FFF);
    send_step(1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_step(1'b0, 16'h8000, 16'h1234, 16'h8000);
    wait_idle();
    // Huge negative return flushes to zero; zero price stays unsaturated.
    write_all(32'h8000_0000, 32'h0, 32'h0001_FFFF, 32'h8000_0000, 32'h0, 32'h0000_0001);
    send_step(1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_step(1'b0, 16'h7FFF, 16'h0000, 16'h7FFF);
    wait_idle();
    // Random phases over several settings.
    write_all(32'h0001_0000, 32'h0200_0000, 32'h0000_1000, 32'hFF00_0000,
              32'h0400_0000, 32'd100 << 16);
    random_phase(200);
    wait_idle();
    write_all($urandom, $urandom, $urandom_range(0, 65536), $urandom, $urandom, $urandom);
    random_phase(150);
    wait_idle();
    write_all($urandom_range(0, 1 << 20) - (1 << 19), $urandom_range(0, 1 << 27),
              $urandom_range(0, 65536), $urandom_range(0, 1 << 26) - (1 << 25),
              $urandom_range(0, 1 << 27), $urandom_range(1 << 16, 1 << 24));
    random_phase(180);
    wait_idle();
    if (fail_count == 0) $display("** jump_diffusion_price_step: PASSED **");
    else $display("** jump_diffusion_price_step: FAILED **");
    $finish;
  end
endmodule

// ===== files.f =====
design/jdps_pkg.sv
design/jdps_front.sv
design/jdps_queue.sv
design/jdps_back.sv
design/jump_diffusion_price_step.sv
test/jdps_checker.sv
test/jump_diffusion_price_step_tb.sv
